// ----- hdl/fsd_pkg.sv -----
// Shared types, constants and helper functions for the Floyd-Steinberg dither unit.
package fsd_pkg;

	localparam int MAX_CHANNELS = 4;
	localparam int CHAN_W = 2;
	localparam int ACC_W = 20;
	localparam int ACC_MAX = 2 ** (ACC_W - 1) - 1;
	localparam int ACC_MIN = -(2 ** (ACC_W - 1));
	localparam int FW_W = 11;
	localparam int FH_W = 16;
	localparam int CC_W = 3;
	localparam int LB_W = 4;
	localparam int CFG_AW = 4;
	localparam int RECIP_W = 23;
	localparam int RECIP_SHIFT = 22;

	typedef enum logic [1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_CHANNELS,
		REG_LEVELS
	} fsd_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ROUND,
		ST_SCALE,
		ST_DIVIDE,
		ST_DIFFUSE,
		ST_FLUSH,
		ST_FINISH
	} fsd_state_t;

	typedef struct packed {
		logic [7:0] sample_0;
		logic [7:0] sample_1;
		logic [7:0] sample_2;
		logic [7:0] sample_3;
	} fsd_in_t;

	typedef struct packed {
		logic [7:0] dithered_0;
		logic [7:0] dithered_1;
		logic [7:0] dithered_2;
		logic [7:0] dithered_3;
		logic       row_end;
		logic       frame_end;
	} fsd_out_t;

	typedef struct packed {
		logic              load;
		logic              read;
		logic              round;
		logic              scale;
		logic              divide;
		logic              diffuse;
		logic              flush;
		logic              emit;
		logic [CHAN_W-1:0] chan;
		logic              last_col;
		logic              last_row;
		logic              row_nz;
		logic              col_nz;
	} fsd_cmd_t;

	// Highest level code for a given bit count; zero bits gives zero.
	function automatic logic [6:0] level_top(input logic [2:0] bits);
		logic [7:0] t;
		t = (8'd1 << bits) - 8'd1;
		return t[6:0];
	endfunction

	// Rounded-up reciprocal of the highest level code, exact for dividends below 2^15.
	function automatic logic [RECIP_W-1:0] level_recip(input logic [2:0] bits);
		logic [RECIP_W-1:0] r;
		unique case (bits)
			3'd0: r = 23'd0;
			3'd1: r = 23'd4194304;
			3'd2: r = 23'd1398102;
			3'd3: r = 23'd599187;
			3'd4: r = 23'd279621;
			3'd5: r = 23'd135301;
			3'd6: r = 23'd66577;
			3'd7: r = 23'd33027;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/floyd_steinberg_dither_unit.sv -----
// Top level of the Floyd-Steinberg dither unit: register port, sequencer and datapath.
//
// Pixels arrive in raster order and leave dithered, one result beat per pixel beat; the
// unit counts columns and rows itself against frame_width and frame_height. Channels go
// one at a time through a single five-step path (line store read, round, scale, reciprocal
// divide, diffuse); a pixel that ends a row with a row below adds a flush step per channel,
// as the line store has one write port. A result register sits on the output, so the next
// pixel is taken while a result waits. The line store holds undefined data after reset and
// needs no clearing; its read data is used only from the second row of a frame on.
// Registers must be written only while the unit is idle; the unit does not enforce this.
module floyd_steinberg_dither_unit
	import fsd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int FRACTION_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  fsd_in_t           pixel,
	output logic              result_valid,
	input  logic              result_stall,
	output fsd_out_t          result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [FW_W-1:0]              frame_width_q;
	logic [FH_W-1:0]              frame_height_q;
	logic [CC_W-1:0]              channel_count_q;
	logic [LB_W-1:0]              level_bits_q;
	fsd_reg_t                     reg_sel;
	logic                         cfg_write;
	fsd_cmd_t                     cmd;
	logic [$clog2(MAX_WIDTH)-1:0] col;

	assign pready = 1'b1;
	assign reg_sel = fsd_reg_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FW_W'(1);
			frame_height_q <= FH_W'(1);
			channel_count_q <= CC_W'(3);
			level_bits_q <= LB_W'(5);
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_WIDTH:    frame_width_q <= pwdata[FW_W-1:0];
				REG_HEIGHT:   frame_height_q <= pwdata[FH_W-1:0];
				REG_CHANNELS: channel_count_q <= pwdata[CC_W-1:0];
				REG_LEVELS:   level_bits_q <= pwdata[LB_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_WIDTH:    prdata = 32'(frame_width_q);
			REG_HEIGHT:   prdata = 32'(frame_height_q);
			REG_CHANNELS: prdata = 32'(channel_count_q);
			REG_LEVELS:   prdata = 32'(level_bits_q);
		endcase
	end

	fsd_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.channel_count(channel_count_q),
		.cmd          (cmd),
		.col          (col)
	);

	fsd_datapath #(
		.MAX_WIDTH    (MAX_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.col       (col),
		.level_bits(level_bits_q),
		.pixel     (pixel),
		.result    (result)
	);

endmodule

// ----- hdl/fsd_ctrl.sv -----
// Sequencer for the dither unit: position tracking, channel stepping and result handoff.
module fsd_ctrl
	import fsd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	output logic                         result_valid,
	input  logic                         result_stall,
	input  logic [FW_W-1:0]              frame_width,
	input  logic [FH_W-1:0]              frame_height,
	input  logic [CC_W-1:0]              channel_count,
	output fsd_cmd_t                     cmd,
	output logic [$clog2(MAX_WIDTH)-1:0] col
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = (XW + 1 > FW_W) ? XW + 1 : FW_W;

	fsd_state_t        state_q, state_d;
	logic [CHAN_W-1:0] chan_q;
	logic [XW-1:0]     col_q, x_q, x_now, wm1;
	logic [FH_W-1:0]   row_q, hm1;
	logic              last_col_q, last_row_q, row_nz_q, out_valid_q;
	logic [WW-1:0]     fw_ext, w_eff;
	logic [CHAN_W-1:0] nch_m1;
	logic              advance;

	always_comb begin
		fw_ext = WW'(frame_width);
		if (fw_ext == '0) begin
			w_eff = WW'(1);
		end else if (fw_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		wm1 = XW'(w_eff - WW'(1));
		x_now = (col_q > wm1) ? wm1 : col_q;
		hm1 = (frame_height == '0) ? '0 : frame_height - FH_W'(1);
		if (channel_count == '0) begin
			nch_m1 = '0;
		end else if (channel_count > CC_W'(MAX_CHANNELS)) begin
			nch_m1 = CHAN_W'(MAX_CHANNELS - 1);
		end else begin
			nch_m1 = CHAN_W'(channel_count - CC_W'(1));
		end
	end

	always_comb begin
		state_d = state_q;
		pixel_stall = 1'b1;
		advance = 1'b0;
		cmd = '0;
		cmd.chan = chan_q;
		cmd.last_col = last_col_q;
		cmd.last_row = last_row_q;
		cmd.row_nz = row_nz_q;
		cmd.col_nz = (x_q != '0);
		unique case (state_q)
			ST_IDLE: begin
				pixel_stall = 1'b0;
				if (pixel_valid) begin
					cmd.load = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.divide = 1'b1;
				state_d = ST_DIFFUSE;
			end
			ST_DIFFUSE: begin
				cmd.diffuse = 1'b1;
				if (last_col_q && !last_row_q) begin
					state_d = ST_FLUSH;
				end else if (chan_q == nch_m1) begin
					state_d = ST_FINISH;
				end else begin
					advance = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				if (chan_q == nch_m1) begin
					state_d = ST_FINISH;
				end else begin
					advance = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !result_stall) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chan_q <= '0;
			col_q <= '0;
			row_q <= '0;
			x_q <= '0;
			last_col_q <= 1'b0;
			last_row_q <= 1'b0;
			row_nz_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				chan_q <= '0;
				x_q <= x_now;
				last_col_q <= (x_now == wm1);
				last_row_q <= (row_q >= hm1);
				row_nz_q <= (row_q != '0);
			end else if (advance) begin
				chan_q <= chan_q + CHAN_W'(1);
			end
			if (cmd.emit) begin
				if (last_col_q) begin
					col_q <= '0;
					row_q <= last_row_q ? '0 : row_q + FH_W'(1);
				end else begin
					col_q <= x_q + XW'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign col = x_q;

endmodule

// ----- hdl/fsd_datapath.sv -----
// Per-channel quantize and error-diffusion datapath with the line error store.
module fsd_datapath
	import fsd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int FRACTION_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fsd_cmd_t                     cmd,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  logic [LB_W-1:0]              level_bits,
	input  fsd_in_t                      pixel,
	output fsd_out_t                     result
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int AW = XW + CHAN_W;
	localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int VW = ((9 + FRACTION_BITS) > ACC_W ? 9 + FRACTION_BITS : ACC_W) + 2;
	localparam int EW = VW + 1;
	localparam int PW = EW + 4;
	localparam logic signed [VW-1:0] HALF = VW'(1) << (FRACTION_BITS - 1);
	localparam logic signed [PW-1:0] SAT_HI = PW'(ACC_MAX);
	localparam logic signed [PW-1:0] SAT_LO = PW'(ACC_MIN);

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [PW-1:0] a);
		logic signed [ACC_W-1:0] r;
		if (a > SAT_HI) begin
			r = ACC_W'(ACC_MAX);
		end else if (a < SAT_LO) begin
			r = ACC_W'(ACC_MIN);
		end else begin
			r = $signed(a[ACC_W-1:0]);
		end
		return r;
	endfunction

	logic signed [ACC_W-1:0] line_mem [DEPTH];
	logic signed [ACC_W-1:0] rd_s1;
	logic signed [VW-1:0]    v_s2;
	logic [14:0]             x1_s2;
	logic [14:0]             y_s3;
	logic [7:0]              out_s4;
	logic signed [ACC_W-1:0] flush_q;
	logic [7:0]              sample_q [MAX_CHANNELS];
	logic [7:0]              res_q [MAX_CHANNELS];
	logic signed [ACC_W-1:0] right_q [MAX_CHANNELS];
	logic signed [ACC_W-1:0] below_q [MAX_CHANNELS];
	logic signed [ACC_W-1:0] below_right_q [MAX_CHANNELS];
	fsd_out_t                result_q;

	logic                    pass;
	logic [6:0]              top;
	logic [7:0]              smp;
	logic signed [VW-1:0]    s_fix, v, t;
	logic [7:0]              r;
	logic [14:0]             x1;
	logic [23:0]             p257;
	logic [14:0]             y;
	logic [37:0]             prod;
	logic [7:0]              outv;
	logic signed [EW-1:0]    err, out_fix;
	logic signed [PW-1:0]    ex, s7, s5, s3, s1;
	logic signed [ACC_W-1:0] left_new, below_new, below_right_new, right_new;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic signed [ACC_W-1:0] wdata;

	always_comb begin
		pass = level_bits[LB_W-1];
		top = level_top(level_bits[2:0]);
		smp = sample_q[cmd.chan];

		s_fix = $signed(VW'(smp)) <<< FRACTION_BITS;
		v = s_fix + VW'(right_q[cmd.chan]) + (cmd.row_nz ? VW'(rd_s1) : '0);
		t = (v + HALF) >>> FRACTION_BITS;
		if (v < 0) begin
			r = 8'd0;
		end else if (t > VW'(255)) begin
			r = 8'd255;
		end else begin
			r = t[7:0];
		end
		x1 = 15'({7'd0, r} * {8'd0, top}) + 15'd127;

		p257 = ({9'd0, x1_s2} + 24'd1) * 24'd257;
		y = 15'({7'd0, p257[23:16]} * 15'd255) + 15'({8'd0, top} >> 1);

		prod = 38'(y_s3) * 38'(level_recip(level_bits[2:0]));
		outv = pass ? smp : prod[RECIP_SHIFT +: 8];

		out_fix = $signed(EW'(out_s4)) <<< FRACTION_BITS;
		err = pass ? '0 : EW'(v_s2) - out_fix;
		ex = PW'(err);
		s7 = ((ex <<< 3) - ex) >>> 4;
		s5 = ((ex <<< 2) + ex) >>> 4;
		s3 = ((ex <<< 1) + ex) >>> 4;
		s1 = ex >>> 4;
		left_new = sat_acc(PW'(below_q[cmd.chan]) + s3);
		below_new = sat_acc(PW'(below_right_q[cmd.chan]) + s5);
		below_right_new = sat_acc(s1);
		right_new = sat_acc(s7);

		we = (cmd.diffuse && cmd.col_nz && !cmd.last_row) || cmd.flush;
		waddr = cmd.flush ? {col, cmd.chan} : {col - XW'(1), cmd.chan};
		wdata = cmd.flush ? flush_q : left_new;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			line_mem[waddr] <= wdata;
		end
		if (cmd.read) begin
			rd_s1 <= line_mem[{col, cmd.chan}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q[0] <= pixel.sample_0;
			sample_q[1] <= pixel.sample_1;
			sample_q[2] <= pixel.sample_2;
			sample_q[3] <= pixel.sample_3;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				res_q[i] <= 8'd0;
			end
		end
		if (cmd.round) begin
			v_s2 <= v;
			x1_s2 <= x1;
		end
		if (cmd.scale) begin
			y_s3 <= y;
		end
		if (cmd.divide) begin
			out_s4 <= outv;
			res_q[cmd.chan] <= outv;
		end
		if (cmd.diffuse && cmd.last_col) begin
			flush_q <= below_new;
		end
		if (cmd.emit) begin
			result_q.dithered_0 <= res_q[0];
			result_q.dithered_1 <= res_q[1];
			result_q.dithered_2 <= res_q[2];
			result_q.dithered_3 <= res_q[3];
			result_q.row_end <= cmd.last_col;
			result_q.frame_end <= cmd.last_col && cmd.last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				right_q[i] <= '0;
				below_q[i] <= '0;
				below_right_q[i] <= '0;
			end
		end else if (cmd.diffuse) begin
			if (cmd.last_col) begin
				right_q[cmd.chan] <= '0;
				below_q[cmd.chan] <= '0;
				below_right_q[cmd.chan] <= '0;
			end else begin
				right_q[cmd.chan] <= right_new;
				below_q[cmd.chan] <= below_new;
				below_right_q[cmd.chan] <= below_right_new;
			end
		end
	end

	assign result = result_q;

endmodule
